FILE: rtl/b64d_pkg.sv
// Shared types, constants and the character decode function of the Base64 stream decoder.
package b64d_pkg;

	// Pad character that closes a group early.
	localparam logic [7:0] CHAR_PAD = 8'h3D;

	// Register index of the output capacity register.
	localparam logic REG_IDX_CAPACITY = 1'b0;

	// Reset value of the output capacity register.
	localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;

	// One result transaction as it travels through the result queue.
	typedef struct packed {
		logic [7:0]  data_byte;
		logic        byte_valid;
		logic        bad_char_seen;
		logic [15:0] decoded_total;
		logic        last_result;
	} res_t;

	// Map a character to {invalid, sextet}; bit 6 is set for characters outside the alphabet.
	function automatic logic [6:0] sextet_of(input logic [7:0] c);
		logic [6:0] r;
		if (c >= 8'h41 && c <= 8'h5A) begin
			r = {1'b0, 6'(c - 8'h41)};
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			r = {1'b0, 6'(c - 8'h61 + 8'd26)};
		end else if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b0, 6'(c - 8'h30 + 8'd52)};
		end else if (c == 8'h2B) begin
			r = {1'b0, 6'd62};
		end else if (c == 8'h2F) begin
			r = {1'b0, 6'd63};
		end else begin
			r = {1'b1, 6'd0};
		end
		return r;
	endfunction

endpackage

FILE: rtl/base64_stream_decoder_top.sv
// The results of a character enter the result queue at its accept edge.
// Throughput: one character per cycle while in_ready is high; results leave one per cycle while out_ready is high.
// Input ready drops while fewer than three queue entries are free (RES_DEPTH sets the queue size).
// Reset: arst_n clears the group state and the queue at once; capacity returns to 65535.
// Top level of the Base64 stream decoder with its APB-style configuration port.
module base64_stream_decoder_top
	import b64d_pkg::*;
#(
	parameter int RES_DEPTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  input_char,
	input  logic        end_of_text,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  data_byte,
	output logic        byte_valid,
	output logic        bad_char_seen,
	output logic [15:0] decoded_total,
	output logic        last_result
);

	logic [15:0] capacity_q;
	logic        in_accept;
	logic [1:0]  res_cnt;
	res_t [2:0]  res;
	res_t        out_data;

	// Configuration register writes and reads.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_IDX_CAPACITY) ? {16'd0, capacity_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_IDX_CAPACITY) begin
			capacity_q <= pwdata[15:0];
		end
	end

	assign in_accept = in_valid && in_ready;

	b64d_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (in_accept),
		.input_char  (input_char),
		.end_of_text (end_of_text),
		.capacity    (capacity_q),
		.res_cnt     (res_cnt),
		.res         (res)
	);

	b64d_fifo #(
		.DEPTH (RES_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_accept),
		.push_cnt  (res_cnt),
		.push_data (res),
		.room      (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// Output transaction fields.
	assign data_byte     = out_data.data_byte;
	assign byte_valid    = out_data.byte_valid;
	assign bad_char_seen = out_data.bad_char_seen;
	assign decoded_total = out_data.decoded_total;
	assign last_result   = out_data.last_result;

endmodule

FILE: rtl/b64d_core.sv
// Decode core: group state and the up to three results produced by one character.
module b64d_core
	import b64d_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  logic [7:0]     input_char,
	input  logic           end_of_text,
	input  logic [15:0]    capacity,
	output logic [1:0]     res_cnt,
	output res_t [2:0]     res
);

	logic [23:0] acc_q, acc_d;
	logic [1:0]  slot_q, slot_d;
	logic        skip_q, skip_d;
	logic [15:0] bc_q, bc_d;
	logic        stop_q, stop_d;
	logic        err_q, err_d;

	logic        stop_now;
	logic [6:0]  sx;
	logic [23:0] acc_new;
	logic [2:0]  emit_n;
	logic [23:0] emit_acc;
	logic [23:0] aligned;
	logic [1:0]  nbytes;

	// Next-state logic for one accepted character.
	always_comb begin
		acc_d    = acc_q;
		slot_d   = slot_q;
		skip_d   = skip_q;
		err_d    = err_q;
		emit_n   = 3'd0;
		emit_acc = acc_q;
		sx       = sextet_of(input_char);
		acc_new  = {acc_q[17:0], (sx[6] ? 6'd0 : sx[5:0])};
		stop_now = stop_q || (!skip_q && slot_q == 2'd0 &&
			({1'b0, bc_q} + 17'd3 >= {1'b0, capacity}));
		if (!stop_now) begin
			if (skip_q) begin
				slot_d = slot_q + 2'd1;
				if (slot_d == 2'd0) begin
					skip_d = 1'b0;
				end
			end else if (input_char == CHAR_PAD) begin
				emit_n   = {1'b0, slot_q};
				emit_acc = acc_q;
				acc_d    = 24'd0;
				if (slot_q == 2'd3) begin
					slot_d = 2'd0;
				end else begin
					slot_d = slot_q + 2'd1;
					skip_d = 1'b1;
				end
			end else begin
				if (sx[6]) begin
					err_d = 1'b1;
				end
				emit_acc = acc_new;
				if (slot_q == 2'd3) begin
					emit_n = 3'd4;
					acc_d  = 24'd0;
					slot_d = 2'd0;
				end else begin
					acc_d  = acc_new;
					slot_d = slot_q + 2'd1;
					if (end_of_text) begin
						emit_n = {1'b0, slot_q} + 3'd1;
					end
				end
			end
		end
		stop_d = stop_now;

		// Left-align the gathered sextets and count the bytes they yield.
		unique case (emit_n)
			3'd4: begin
				aligned = emit_acc;
				nbytes  = 2'd3;
			end
			3'd3: begin
				aligned = {emit_acc[17:0], 6'd0};
				nbytes  = 2'd2;
			end
			3'd2: begin
				aligned = {emit_acc[11:0], 12'd0};
				nbytes  = 2'd1;
			end
			default: begin
				aligned = {emit_acc[5:0], 18'd0};
				nbytes  = 2'd0;
			end
		endcase

		// Build the result transactions.
		for (int k = 0; k < 3; k++) begin
			res[k].data_byte     = aligned[23 - 8 * k -: 8];
			res[k].byte_valid    = 1'b1;
			res[k].bad_char_seen = err_d;
			res[k].decoded_total = bc_q + 16'(k + 1);
			res[k].last_result   = end_of_text && (2'(k) == nbytes - 2'd1);
		end
		res_cnt = nbytes;
		if (end_of_text && nbytes == 2'd0) begin
			res[0].data_byte     = 8'd0;
			res[0].byte_valid    = 1'b0;
			res[0].decoded_total = bc_q;
			res[0].last_result   = 1'b1;
			res_cnt              = 2'd1;
		end
		bc_d = bc_q + 16'(nbytes);

		// The end of a string returns all group state to its reset value.
		if (end_of_text) begin
			acc_d  = 24'd0;
			slot_d = 2'd0;
			skip_d = 1'b0;
			bc_d   = 16'd0;
			stop_d = 1'b0;
			err_d  = 1'b0;
		end
	end

	// Group state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= 24'd0;
			slot_q <= 2'd0;
			skip_q <= 1'b0;
			bc_q   <= 16'd0;
			stop_q <= 1'b0;
			err_q  <= 1'b0;
		end else if (accept) begin
			acc_q  <= acc_d;
			slot_q <= slot_d;
			skip_q <= skip_d;
			bc_q   <= bc_d;
			stop_q <= stop_d;
			err_q  <= err_d;
		end
	end

	// The last character of a string always yields a final result.
	a_eot_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && end_of_text) |-> (res_cnt != 2'd0 && res[res_cnt - 2'd1].last_result))
		else $error("end of text produced no final result");

	// After the end of a string the group state starts over.
	a_eot_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && end_of_text) |=> (bc_q == 16'd0 && slot_q == 2'd0 && !skip_q && !stop_q))
		else $error("group state not cleared after end of text");

endmodule

FILE: rtl/b64d_fifo.sv
// Result queue: takes up to three results per cycle and hands out one per cycle while out_ready is high.
module b64d_fifo
	import b64d_pkg::*;
#(
	parameter int DEPTH = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic [1:0] push_cnt,
	input  res_t [2:0] push_data,
	output logic       room,
	output logic       out_valid,
	input  logic       out_ready,
	output res_t       out_data
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW:0] DEPTH_W = (PW + 1)'(DEPTH);
	localparam logic [CW-1:0] ROOM_MAX = CW'(DEPTH - 3);

	res_t          mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] count_q;
	logic          pop;
	logic [1:0]    push_n;

	// Pointer advance with wrap at the queue depth.
	function automatic logic [PW-1:0] ptr_add(input logic [PW-1:0] p, input logic [1:0] k);
		logic [PW:0] s;
		s = {1'b0, p} + (PW + 1)'(k);
		if (s >= DEPTH_W) begin
			s = s - DEPTH_W;
		end
		return s[PW-1:0];
	endfunction

	assign room      = (count_q <= ROOM_MAX);
	assign out_valid = (count_q != '0);
	assign out_data  = mem_q[rd_q];
	assign pop       = out_valid && out_ready;
	assign push_n    = push ? push_cnt : 2'd0;

	// Entry storage; entries are written at consecutive slots from the write pointer.
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			if (2'(k) < push_n) begin
				mem_q[ptr_add(wr_q, 2'(k))] <= push_data[k];
			end
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= ptr_add(wr_q, push_n);
			rd_q    <= ptr_add(rd_q, {1'b0, pop});
			count_q <= count_q + CW'(push_n) - CW'(pop);
		end
	end

	// The fill count never goes beyond the depth.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("result queue overflow");

	// Results are only pushed while three entries are free.
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push && push_cnt != 2'd0) |-> room)
		else $error("push without room");

	// A pop alone lowers the fill count by one.
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && push_n == 2'd0) |=> count_q == $past(count_q) - CW'(1))
		else $error("fill count wrong after pop");

endmodule
